>>> hdl/prs_pkg.sv
// shared types, codes and constants of the packet range selector
package prs_pkg;

   // table depth default and queue depth between front and back
   localparam int RANGE_DEPTH_DEF = 32;
   localparam int QUEUE_DEPTH = 2;

   // function codes on the request channel
   localparam logic [1:0] FUNC_PACKET = 2'd0;
   localparam logic [1:0] FUNC_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_START  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // decision codes on the response channel
   localparam logic [1:0] DEC_NEXT     = 2'd0;
   localparam logic [1:0] DEC_THIS     = 2'd1;
   localparam logic [1:0] DEC_FINISHED = 2'd2;

   // register indexes of the control port
   localparam logic [2:0] CSR_MODE_FILTERED      = 3'd0;
   localparam logic [2:0] CSR_MODE_MARKED        = 3'd1;
   localparam logic [2:0] CSR_MODE_CURRENT_ONLY  = 3'd2;
   localparam logic [2:0] CSR_MODE_MARKED_SPAN   = 3'd3;
   localparam logic [2:0] CSR_MODE_MANUAL_RANGES = 3'd4;
   localparam logic [2:0] CSR_CURRENT_PACKET     = 3'd5;
   localparam logic [2:0] CSR_MARKED_TOTAL       = 3'd6;
   localparam logic [2:0] CSR_RANGES_IN_USE      = 3'd7;

   // work kinds after classification in the front
   typedef enum logic [1:0] {
      KIND_PACKET,
      KIND_LOAD,
      KIND_START,
      KIND_NOP
   } kind_type;

   // one classified beat waiting for the back
   typedef struct packed {
      kind_type    kind;
      logic [31:0] number;
      logic        filt;
      logic        mark;
      logic [4:0]  idx;
      logic [31:0] low;
      logic [31:0] high;
   } item_type;

   // configuration seen by the back
   typedef struct packed {
      logic        mode_filtered;
      logic        mode_marked;
      logic        mode_current_only;
      logic        mode_marked_span;
      logic        mode_manual_ranges;
      logic [31:0] current_packet_number;
      logic [31:0] marked_total;
      logic [5:0]  ranges_in_use;
   } cfg_type;

endpackage

>>> hdl/prs_ifs.sv
// request and response channel interfaces of the packet range selector
interface prs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] packet_number;
   logic        passed_filter;
   logic        is_marked;
   logic [4:0]  entry_index;
   logic [31:0] entry_low;
   logic [31:0] entry_high;

   modport source (output valid, func, packet_number, passed_filter, is_marked,
                   entry_index, entry_low, entry_high, input ready);
   modport sink (input valid, func, packet_number, passed_filter, is_marked,
                 entry_index, entry_low, entry_high, output ready);
endinterface

interface prs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] decision;
   logic       in_range;

   modport source (output valid, decision, in_range, input ready);
   modport sink (input valid, decision, in_range, output ready);
endinterface

>>> hdl/packet_range_selector.sv
// top level of the packet range selector: control registers, front, queue and back
// Each request beat gets exactly one response beat, in order. Range loads, start
// beats and unused function codes answer in the cycle after they leave the queue;
// a packet beat scans the range table one entry per cycle through the table's
// single read port, at most min(ranges_in_use, RANGE_DEPTH) entries, and stops
// early when an entry matches. The queue in front of the back holds two beats, and
// the response register lets the next packet beat scan while a finished one waits.
// Control registers may be written only while no beat is in flight.
module packet_range_selector #(
   parameter int RANGE_DEPTH = prs_pkg::RANGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   prs_req_if.sink     req_bus,
   prs_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import prs_pkg::*;

   // control register values after reset
   localparam cfg_type CFG_RESET = '{
      mode_filtered:         1'b0,
      mode_marked:           1'b0,
      mode_current_only:     1'b0,
      mode_marked_span:      1'b0,
      mode_manual_ranges:    1'b0,
      current_packet_number: 32'd0,
      marked_total:          32'd0,
      ranges_in_use:         6'd1
   };

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, full, pop, pop_valid;
   item_type push_item, pop_item;

   // control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE_FILTERED:      cfg_in.mode_filtered = csr_wdata[0];
            CSR_MODE_MARKED:        cfg_in.mode_marked = csr_wdata[0];
            CSR_MODE_CURRENT_ONLY:  cfg_in.mode_current_only = csr_wdata[0];
            CSR_MODE_MARKED_SPAN:   cfg_in.mode_marked_span = csr_wdata[0];
            CSR_MODE_MANUAL_RANGES: cfg_in.mode_manual_ranges = csr_wdata[0];
            CSR_CURRENT_PACKET:     cfg_in.current_packet_number = csr_wdata;
            CSR_MARKED_TOTAL:       cfg_in.marked_total = csr_wdata;
            CSR_RANGES_IN_USE:      cfg_in.ranges_in_use = csr_wdata[5:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept and classify
   prs_front #(.RANGE_DEPTH(RANGE_DEPTH)) u_front (
      .req        (req_bus),
      .full       (full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // decoupling queue
   prs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // table, scan and decision
   prs_back #(.RANGE_DEPTH(RANGE_DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (pop_valid),
      .q_item  (pop_item),
      .q_pop   (pop),
      .rsp     (rsp_bus)
   );
endmodule

>>> hdl/prs_front.sv
// front: accepts request beats, classifies them and orders range bounds
module prs_front #(
   parameter int RANGE_DEPTH = prs_pkg::RANGE_DEPTH_DEF
) (
   prs_req_if.sink           req,
   input  logic              full,
   output logic              push_valid,
   output prs_pkg::item_type push_item
);
   import prs_pkg::*;

   logic a_le_b;

   // accept whenever the queue has room
   assign req.ready  = !full;
   assign push_valid = req.valid && !full;

   // order the two bounds of a range entry
   assign a_le_b = req.entry_low <= req.entry_high;

   always_comb begin
      push_item.number = req.packet_number;
      push_item.filt   = req.passed_filter;
      push_item.mark   = req.is_marked;
      push_item.idx    = req.entry_index;
      push_item.low    = a_le_b ? req.entry_low : req.entry_high;
      push_item.high   = a_le_b ? req.entry_high : req.entry_low;
      // classify the function code; loads past the table end do nothing
      unique case (req.func)
         FUNC_PACKET: push_item.kind = KIND_PACKET;
         FUNC_LOAD: begin
            if (32'(req.entry_index) < RANGE_DEPTH) begin
               push_item.kind = KIND_LOAD;
            end else begin
               push_item.kind = KIND_NOP;
            end
         end
         FUNC_START:  push_item.kind = KIND_START;
         FUNC_UNUSED: push_item.kind = KIND_NOP;
         default:     push_item.kind = KIND_NOP;
      endcase
   end
endmodule

>>> hdl/prs_queue.sv
// short queue of classified beats between front and back
module prs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  prs_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output prs_pkg::item_type pop_item
);
   import prs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == CNT_FULL;
   assign pop_valid = count_ff != '0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

>>> hdl/prs_back.sv
// back: range table, entry scan, pass state and the decision output register
module prs_back #(
   parameter int RANGE_DEPTH = prs_pkg::RANGE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  prs_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  prs_pkg::item_type q_item,
   output logic              q_pop,
   prs_rsp_if.source         rsp
);
   import prs_pkg::*;

   localparam int IDX_W = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
   localparam int CNT_W = $clog2(RANGE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      num_ff, num_in;
   logic             filt_ff, filt_in;
   logic             mark_ff, mark_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             hit_ff, hit_in;
   logic [31:0]      countdown_ff, countdown_in;
   logic             span_active_ff, span_active_in;
   logic             current_done_ff, current_done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_decision_ff, rsp_decision_in;
   logic             rsp_in_range_ff, rsp_in_range_in;

   logic [63:0]      range_mem_ff [RANGE_DEPTH];
   logic [63:0]      rd_data_ff;
   logic             mem_we, rd_en;
   logic [CNT_W-1:0] count_sat;
   logic             out_free;

   // decision results
   logic [1:0]  dec_val;
   logic [31:0] dec_countdown;
   logic        dec_span, dec_done, pass, fin;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.decision = rsp_decision_ff;
   assign rsp.in_range = rsp_in_range_ff;
   assign out_free     = !rsp_valid_ff || rsp.ready;

   // entries checked, clipped to the table depth
   assign count_sat = (32'(cfg.ranges_in_use) > RANGE_DEPTH) ? CNT_W'(RANGE_DEPTH)
                                                               : CNT_W'(cfg.ranges_in_use);

   // table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         range_mem_ff[IDX_W'(q_item.idx)] <= {q_item.low, q_item.high};
      end
      if (rd_en) begin
         rd_data_ff <= range_mem_ff[issue_ff[IDX_W-1:0]];
      end
   end

   // selection decision for the held packet
   always_comb begin
      dec_val       = DEC_THIS;
      dec_countdown = countdown_ff;
      dec_span      = span_active_ff;
      dec_done      = current_done_ff;
      fin           = 1'b0;
      pass = (!cfg.mode_filtered && !cfg.mode_marked) ||
             (cfg.mode_filtered && filt_ff && !cfg.mode_marked) ||
             (cfg.mode_marked && mark_ff && !cfg.mode_filtered) ||
             (cfg.mode_filtered && cfg.mode_marked && filt_ff && mark_ff) ||
             cfg.mode_current_only || cfg.mode_marked_span ||
             cfg.mode_manual_ranges || span_active_ff;
      if (!pass) begin
         dec_val = DEC_NEXT;
         fin     = 1'b1;
      end
      // manual ranges need a table hit and, in filtered mode, a passed filter
      if (!fin && cfg.mode_manual_ranges) begin
         if ((cfg.mode_filtered && !filt_ff) || !hit_ff) begin
            dec_val = DEC_NEXT;
            fin     = 1'b1;
         end
      end
      // marked span counts marked packets down to the last one
      if (!fin && cfg.mode_marked_span) begin
         if (countdown_ff == '0) begin
            dec_val = DEC_FINISHED;
            fin     = 1'b1;
         end else begin
            if (mark_ff) begin
               dec_span      = 1'b1;
               dec_countdown = countdown_ff - 1'b1;
            end
            if ((cfg.mode_filtered && !filt_ff) || !dec_span) begin
               dec_val = DEC_NEXT;
               fin     = 1'b1;
            end
         end
      end
      // current packet only, once
      if (!fin && cfg.mode_current_only) begin
         if (current_done_ff) begin
            dec_val = DEC_FINISHED;
         end else if (num_ff != cfg.current_packet_number) begin
            dec_val = DEC_NEXT;
         end else begin
            dec_done = 1'b1;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      num_in          = num_ff;
      filt_in         = filt_ff;
      mark_in         = mark_ff;
      count_in        = count_ff;
      issue_in        = issue_ff;
      rd_valid_in     = 1'b0;
      hit_in          = hit_ff;
      countdown_in    = countdown_ff;
      span_active_in  = span_active_ff;
      current_done_in = current_done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_decision_in = rsp_decision_ff;
      rsp_in_range_in = rsp_in_range_ff;
      q_pop           = 1'b0;
      mem_we          = 1'b0;
      rd_en           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // a packet beat needs the response register only at its decision
            if (q_valid && (out_free || q_item.kind == KIND_PACKET)) begin
               q_pop = 1'b1;
               if (q_item.kind == KIND_PACKET) begin
                  num_in   = q_item.number;
                  filt_in  = q_item.filt;
                  mark_in  = q_item.mark;
                  count_in = count_sat;
                  issue_in = '0;
                  hit_in   = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  // non-packet beats answer at once with a plain skip
                  rsp_valid_in    = 1'b1;
                  rsp_decision_in = DEC_NEXT;
                  rsp_in_range_in = 1'b0;
                  if (q_item.kind == KIND_LOAD) begin
                     mem_we = 1'b1;
                  end
                  if (q_item.kind == KIND_START) begin
                     countdown_in    = cfg.marked_total;
                     span_active_in  = 1'b0;
                     current_done_in = 1'b0;
                  end
               end
            end
         end
         ST_SCAN: begin
            // one entry read per cycle, compared in the next cycle
            rd_en       = (issue_ff < count_ff) && !hit_ff;
            rd_valid_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            if (rd_valid_ff && (num_ff >= rd_data_ff[63:32]) &&
                (num_ff <= rd_data_ff[31:0])) begin
               hit_in = 1'b1;
            end
            if (!rd_en && !rd_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_decision_in = dec_val;
               rsp_in_range_in = hit_ff;
               countdown_in    = dec_countdown;
               span_active_in  = dec_span;
               current_done_in = dec_done;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rd_valid_ff     <= 1'b0;
         countdown_ff    <= '0;
         span_active_ff  <= 1'b0;
         current_done_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rd_valid_ff     <= rd_valid_in;
         countdown_ff    <= countdown_in;
         span_active_ff  <= span_active_in;
         current_done_ff <= current_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      num_ff          <= num_in;
      filt_ff         <= filt_in;
      mark_ff         <= mark_in;
      count_ff        <= count_in;
      issue_ff        <= issue_in;
      hit_ff          <= hit_in;
      rsp_decision_ff <= rsp_decision_in;
      rsp_in_range_ff <= rsp_in_range_in;
   end
endmodule

>>> verif/prs_checker.sv
`timescale 1ns / 1ps
// beat monitor and decision predictor for the packet range selector
module prs_checker #(
   parameter int RANGE_DEPTH = prs_pkg::RANGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   prs_req_if          req_mon,
   prs_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   import prs_pkg::*;

   typedef struct packed {
      logic [1:0] decision;
      logic       in_range;
   } verdict_t;

   // own copy of the control registers and the selector state
   cfg_type     regs;
   logic [31:0] row_lo [RANGE_DEPTH];
   logic [31:0] row_hi [RANGE_DEPTH];
   logic [31:0] marks_left;
   logic        span_on;
   logic        current_taken;

   verdict_t    pending_verdicts [$];
   verdict_t    want;
   int          mismatches = 0;

   assign fail_count = mismatches;

   // scan of the checked part of the range table
   function automatic logic number_hits_table(input logic [31:0] number);
      int rows;
      rows = (regs.ranges_in_use > RANGE_DEPTH) ? RANGE_DEPTH : regs.ranges_in_use;
      for (int i = 0; i < rows; i++) begin
         if (number >= row_lo[i] && number <= row_hi[i])
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // process / skip / finished, updating span and current-packet flags
   function automatic logic [1:0] packet_decision(input logic [31:0] number,
                                                  input logic filt, input logic mark,
                                                  input logic hit);
      logic mf, mm, admit;
      mf = regs.mode_filtered;
      mm = regs.mode_marked;
      admit = (!mf && !mm) || (mf && filt && !mm) || (mm && mark && !mf) ||
              (mf && mm && filt && mark) || regs.mode_current_only ||
              regs.mode_marked_span || regs.mode_manual_ranges || span_on;
      if (!admit)
         return DEC_NEXT;

      if (regs.mode_manual_ranges) begin
         if (mf && !filt)
            return DEC_NEXT;
         if (!hit)
            return DEC_NEXT;
      end

      // countdown at zero ends the pass and stays at zero
      if (regs.mode_marked_span) begin
         if (marks_left == 32'd0)
            return DEC_FINISHED;
         if (mark) begin
            span_on = 1'b1;
            marks_left = marks_left - 32'd1;
         end
         if (mf && !filt)
            return DEC_NEXT;
         if (!span_on)
            return DEC_NEXT;
      end

      if (regs.mode_current_only) begin
         if (current_taken)
            return DEC_FINISHED;
         if (number != regs.current_packet_number)
            return DEC_NEXT;
         current_taken = 1'b1;
      end

      return DEC_THIS;
   endfunction

   // expected response for one request beat, state updated in order
   function automatic verdict_t predict_verdict(input logic [1:0] func,
                                                input logic [31:0] number,
                                                input logic filt, input logic mark,
                                                input logic [4:0] idx,
                                                input logic [31:0] lo, input logic [31:0] hi);
      verdict_t v;
      v.decision = DEC_NEXT;
      v.in_range = 1'b0;
      case (func)
         FUNC_PACKET: begin
            v.in_range = number_hits_table(number);
            v.decision = packet_decision(number, filt, mark, v.in_range);
         end
         FUNC_LOAD: begin
            // out-of-order bounds are swapped
            if (idx < RANGE_DEPTH) begin
               row_lo[idx] = (lo <= hi) ? lo : hi;
               row_hi[idx] = (lo <= hi) ? hi : lo;
            end
         end
         FUNC_START: begin
            marks_left = regs.marked_total;
            span_on = 1'b0;
            current_taken = 1'b0;
         end
         default: ;
      endcase
      return v;
   endfunction

   // watch control writes, request and response beats
   always @(posedge clock) begin
      if (reset) begin
         regs = '0;
         regs.ranges_in_use = 6'd1;
         marks_left = '0;
         span_on = 1'b0;
         current_taken = 1'b0;
         pending_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE_FILTERED:      regs.mode_filtered = csr_wdata[0];
               CSR_MODE_MARKED:        regs.mode_marked = csr_wdata[0];
               CSR_MODE_CURRENT_ONLY:  regs.mode_current_only = csr_wdata[0];
               CSR_MODE_MARKED_SPAN:   regs.mode_marked_span = csr_wdata[0];
               CSR_MODE_MANUAL_RANGES: regs.mode_manual_ranges = csr_wdata[0];
               CSR_CURRENT_PACKET:     regs.current_packet_number = csr_wdata;
               CSR_MARKED_TOTAL:       regs.marked_total = csr_wdata;
               CSR_RANGES_IN_USE:      regs.ranges_in_use = csr_wdata[5:0];
               default: ;
            endcase
         end

         // compare before pushing so a same-edge request cannot cover a stray beat
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected response beat: decision %0d in_range %0d",
                      rsp_mon.decision, rsp_mon.in_range);
               mismatches++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_mon.decision !== want.decision) begin
                  $error("decision: expected %0d, got %0d", want.decision, rsp_mon.decision);
                  mismatches++;
               end
               if (rsp_mon.in_range !== want.in_range) begin
                  $error("in_range: expected %0d, got %0d", want.in_range, rsp_mon.in_range);
                  mismatches++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            pending_verdicts.push_back(predict_verdict(req_mon.func, req_mon.packet_number,
                                                       req_mon.passed_filter,
                                                       req_mon.is_marked,
                                                       req_mon.entry_index,
                                                       req_mon.entry_low,
                                                       req_mon.entry_high));
      end
      outstanding <= pending_verdicts.size();
   end

endmodule

>>> verif/tb_packet_range_selector.sv
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the packet range selector
module tb_packet_range_selector;
   import prs_pkg::*;

   localparam int DEPTH        = RANGE_DEPTH_DEF;
   localparam int RUN_BEATS    = 630;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 240;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] number;
      logic        filt;
      logic        mark;
      logic [4:0]  idx;
      logic [31:0] lo;
      logic [31:0] hi;
   } beat_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          outstanding;
   int          cycle_count = 0;
   int          beats_sent = 0;
   int          rsp_seen = 0;
   bit          calm_sender = 1'b0;
   bit          calm_receiver = 1'b0;
   logic [DEPTH-1:0] rows_loaded = '0;
   logic [31:0] bound_pool [2*DEPTH];

   prs_req_if req_ch ();
   prs_rsp_if rsp_ch ();

   packet_range_selector #(.RANGE_DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   prs_checker #(.RANGE_DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 100 MHz clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // beat builders, unused fields carry random noise
   function automatic beat_type packet_beat(input logic [31:0] number, input logic filt,
                                            input logic mark);
      beat_type b;
      b.func = FUNC_PACKET;
      b.number = number;
      b.filt = filt;
      b.mark = mark;
      b.idx = 5'($urandom);
      b.lo = $urandom;
      b.hi = $urandom;
      return b;
   endfunction

   function automatic beat_type load_beat(input logic [4:0] idx, input logic [31:0] lo,
                                          input logic [31:0] hi);
      beat_type b;
      b.func = FUNC_LOAD;
      b.number = $urandom;
      b.filt = 1'($urandom);
      b.mark = 1'($urandom);
      b.idx = idx;
      b.lo = lo;
      b.hi = hi;
      return b;
   endfunction

   function automatic beat_type control_beat(input logic [1:0] func);
      beat_type b;
      b.func = func;
      b.number = $urandom;
      b.filt = 1'($urandom);
      b.mark = 1'($urandom);
      b.idx = 5'($urandom);
      b.lo = $urandom;
      b.hi = $urandom;
      return b;
   endfunction

   // offer one request beat after a random gap and wait for acceptance
   task automatic send_beat(input beat_type b);
      int gap;
      gap = calm_sender ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.func          <= b.func;
      req_ch.packet_number <= b.number;
      req_ch.passed_filter <= b.filt;
      req_ch.is_marked     <= b.mark;
      req_ch.entry_index   <= b.idx;
      req_ch.entry_low     <= b.lo;
      req_ch.entry_high    <= b.hi;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
      if (b.func == FUNC_LOAD) begin
         rows_loaded[b.idx] = 1'b1;
         bound_pool[2*b.idx] = b.lo;
         bound_pool[2*b.idx+1] = b.hi;
      end
   endtask

   // stop offering and wait until every response is back
   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write every control register, block idle
   task automatic program_regs(input cfg_type c);
      write_reg(CSR_MODE_FILTERED, {31'd0, c.mode_filtered});
      write_reg(CSR_MODE_MARKED, {31'd0, c.mode_marked});
      write_reg(CSR_MODE_CURRENT_ONLY, {31'd0, c.mode_current_only});
      write_reg(CSR_MODE_MARKED_SPAN, {31'd0, c.mode_marked_span});
      write_reg(CSR_MODE_MANUAL_RANGES, {31'd0, c.mode_manual_ranges});
      write_reg(CSR_CURRENT_PACKET, c.current_packet_number);
      write_reg(CSR_MARKED_TOTAL, c.marked_total);
      write_reg(CSR_RANGES_IN_USE, {26'd0, c.ranges_in_use});
      csr_wr_en <= 1'b0;
   endtask

   // response side: random stalls, calm stretches, two long hold-offs
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_seen == 100 || rsp_seen == 420)
            stall = HOLD_CYCLES;
         else
            stall = calm_receiver ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         rsp_seen++;
         if (rsp_seen % 40 == 0)
            calm_receiver = ($urandom_range(0, 3) == 0);
      end
   end

   // request side and verdict
   initial begin
      cfg_type     setup;
      int          ready_rows;
      int          phase_len;
      int          pick;
      bit          first_phase;
      logic [4:0]  row;
      logic [31:0] num;
      logic [31:0] lo;
      logic [31:0] hi;

      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_MODE_FILTERED;
      csr_wdata            <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.func          <= FUNC_PACKET;
      req_ch.packet_number <= '0;
      req_ch.passed_filter <= 1'b0;
      req_ch.is_marked     <= 1'b0;
      req_ch.entry_index   <= '0;
      req_ch.entry_low     <= '0;
      req_ch.entry_high    <= '0;
      for (int i = 0; i < 2*DEPTH; i++)
         bound_pool[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: swapped bounds, range edges, field extremes, every function
      send_beat(load_beat(5'd0, 32'd500, 32'd100));
      send_beat(load_beat(5'd1, 32'd0, 32'd0));
      send_beat(load_beat(5'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_beat(packet_beat(32'd100, 1'b0, 1'b0));
      send_beat(packet_beat(32'd500, 1'b1, 1'b1));
      send_beat(packet_beat(32'd99, 1'b1, 1'b0));
      send_beat(packet_beat(32'd0, 1'b0, 1'b1));
      send_beat(packet_beat(32'hFFFF_FFFF, 1'b1, 1'b1));
      send_beat(control_beat(FUNC_UNUSED));
      send_beat(control_beat(FUNC_START));

      // filtered and marked together, no range entry checked
      wait_results_drained();
      setup = '0;
      setup.mode_filtered = 1'b1;
      setup.mode_marked = 1'b1;
      program_regs(setup);
      send_beat(packet_beat(32'd300, 1'b1, 1'b1));
      send_beat(packet_beat(32'd300, 1'b1, 1'b0));
      send_beat(packet_beat(32'd300, 1'b0, 1'b1));

      // marked span over two marks, then the countdown runs out
      wait_results_drained();
      setup = '0;
      setup.mode_marked_span = 1'b1;
      setup.marked_total = 32'd2;
      setup.ranges_in_use = 6'd1;
      program_regs(setup);
      send_beat(control_beat(FUNC_START));
      send_beat(packet_beat(32'd10, 1'b1, 1'b0));
      send_beat(packet_beat(32'd11, 1'b1, 1'b1));
      send_beat(packet_beat(32'd12, 1'b1, 1'b0));
      send_beat(packet_beat(32'd13, 1'b0, 1'b1));
      send_beat(packet_beat(32'd14, 1'b1, 1'b0));

      // current packet only, gated by manual ranges
      wait_results_drained();
      setup = '0;
      setup.mode_current_only = 1'b1;
      setup.mode_manual_ranges = 1'b1;
      setup.current_packet_number = 32'd200;
      setup.ranges_in_use = 6'd1;
      program_regs(setup);
      send_beat(control_beat(FUNC_START));
      send_beat(packet_beat(32'd50, 1'b1, 1'b1));
      send_beat(packet_beat(32'd200, 1'b0, 1'b0));
      send_beat(packet_beat(32'd300, 1'b1, 1'b1));

      // random phases: new settings, mostly a start and then a run of packets
      first_phase = 1'b1;
      while (beats_sent < RUN_BEATS) begin
         ready_rows = 0;
         while (ready_rows < DEPTH && rows_loaded[ready_rows])
            ready_rows++;

         setup = '0;
         setup.mode_filtered = 1'($urandom_range(0, 1));
         setup.mode_marked = 1'($urandom_range(0, 1));
         setup.mode_current_only = 1'($urandom_range(0, 1));
         setup.mode_marked_span = 1'($urandom_range(0, 1));
         setup.mode_manual_ranges = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: setup.current_packet_number = 32'd0;
            1: setup.current_packet_number = 32'hFFFF_FFFF;
            2: setup.current_packet_number = $urandom;
            default: setup.current_packet_number = $urandom_range(0, 2100);
         endcase
         case ($urandom_range(0, 4))
            0: setup.marked_total = 32'd0;
            1: setup.marked_total = 32'hFFFF_FFFF;
            default: setup.marked_total = $urandom_range(1, 8);
         endcase
         // never check an entry that was not loaded
         case ($urandom_range(0, 5))
            0: setup.ranges_in_use = 6'd0;
            1: setup.ranges_in_use = 6'd1;
            2: setup.ranges_in_use = 6'(ready_rows);
            3: setup.ranges_in_use = (ready_rows == DEPTH) ? 6'd63 : 6'(ready_rows);
            default: setup.ranges_in_use =
               6'($urandom_range(1, (ready_rows == DEPTH) ? 63 : ready_rows));
         endcase

         calm_sender = ($urandom_range(0, 3) == 0);
         wait_results_drained();
         program_regs(setup);

         if (first_phase) begin
            for (int i = 0; i < DEPTH; i++) begin
               lo = $urandom_range(0, 2000);
               hi = lo + $urandom_range(0, 80);
               send_beat($urandom_range(0, 1) ? load_beat(5'(i), lo, hi)
                                              : load_beat(5'(i), hi, lo));
            end
            first_phase = 1'b0;
         end
         if ($urandom_range(0, 4) != 0)
            send_beat(control_beat(FUNC_START));

         phase_len = $urandom_range(20, 60);
         for (int n = 0; n < phase_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               // packet numbers aimed at the current number and the range edges
               case ($urandom_range(0, 6))
                  0: num = setup.current_packet_number;
                  1: num = setup.current_packet_number +
                           ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
                  2: begin
                     num = bound_pool[$urandom_range(0, 2*DEPTH-1)];
                     num = num + 32'($urandom_range(0, 2)) - 32'd1;
                  end
                  3: num = $urandom;
                  4: num = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
                  default: num = $urandom_range(0, 2100);
               endcase
               send_beat(packet_beat(num, 1'($urandom_range(0, 1)),
                                     $urandom_range(0, 2) == 0));
            end else if (pick < 84) begin
               row = 5'($urandom_range(0, DEPTH-1));
               if ($urandom_range(0, 5) == 0) begin
                  lo = $urandom;
                  hi = $urandom;
               end else begin
                  lo = $urandom_range(0, 2000);
                  hi = lo + $urandom_range(0, 80);
               end
               send_beat($urandom_range(0, 1) ? load_beat(row, lo, hi)
                                              : load_beat(row, hi, lo));
            end else if (pick < 93) begin
               send_beat(control_beat(FUNC_START));
            end else begin
               send_beat(control_beat(FUNC_UNUSED));
            end
         end
      end

      // drain, then let the back settle before the verdict
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
